### rtl/trpd_pkg.sv
// Shared types, constants and helper functions of the TGA run-length pixel decoder.
`default_nettype none
package trpd_pkg;

  // Configuration register indexes.
  localparam logic [2:0] CFG_PIXEL_BYTES     = 3'd0;
  localparam logic [2:0] CFG_RLE_MODE        = 3'd1;
  localparam logic [2:0] CFG_SWAP_RED_BLUE   = 3'd2;
  localparam logic [2:0] CFG_MAP_MODE        = 3'd3;
  localparam logic [2:0] CFG_MAP_ENTRY_BYTES = 3'd4;
  localparam logic [2:0] CFG_MAP_ENTRIES     = 3'd5;
  localparam logic [2:0] CFG_MAP_FIRST_INDEX = 3'd6;
  localparam logic [2:0] CFG_IMAGE_PIXELS    = 3'd7;

  localparam int CFG_W = 29;

  // Defaults of the top-level parameters.
  localparam int DEF_PALETTE_DEPTH = 256;
  localparam int DEF_MAX_SIDE      = 16384;

  // Width of a palette index carried between front and back.
  localparam int IDX_W = 8;

  // Queue between the front and the back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Reciprocal of three for 11-bit dividends: (n * 683) >> 11 is exact.
  localparam int RECIP3       = 683;
  localparam int RECIP3_SHIFT = 11;

  // One queue entry: a palette write or a finished pixel result.
  typedef struct packed {
    logic             is_write;
    logic             lookup;
    logic [31:0]      word;
    logic [IDX_W-1:0] addr;
    logic [7:0]       count;
    logic             last;
    logic             clipped;
    logic             bad;
  } qent_t;

  // Byte counts of zero act as one, counts above four act as four.
  function automatic logic [2:0] clamp_bytes(input logic [2:0] v);
    logic [2:0] r;
    if (v == 3'd0) begin
      r = 3'd1;
    end else if (v > 3'd4) begin
      r = 3'd4;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Exchange bytes 0 and 2 of a color word.
  function automatic logic [31:0] swap02(input logic [31:0] v);
    return {v[31:24], v[7:0], v[15:8], v[23:16]};
  endfunction

  // Divide an 11-bit count by a byte count of 1 to 4.
  function automatic logic [10:0] div_small(input logic [10:0] n, input logic [2:0] e);
    logic [21:0] prod;
    logic [10:0] r;
    prod = 22'(n) * 22'(RECIP3);
    unique case (e)
      3'd1:    r = n;
      3'd2:    r = n >> 1;
      3'd3:    r = 11'(prod >> RECIP3_SHIFT);
      default: r = n >> 2;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/trpd_front.sv
// Front part: configuration registers, byte parsing, palette assembly and run accounting.
`default_nettype none
module trpd_front #(
  parameter int PALETTE_DEPTH = trpd_pkg::DEF_PALETTE_DEPTH,
  parameter int MAX_SIDE      = trpd_pkg::DEF_MAX_SIDE
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [2:0]                cfg_index,
  input  wire logic [trpd_pkg::CFG_W-1:0] cfg_data,
  input  wire logic                      accept,
  input  wire logic [7:0]                data_byte,
  input  wire logic                      image_start,
  output logic                           push,
  output trpd_pkg::qent_t                item
);

  localparam logic [1:0] PH_PALETTE = 2'd0;
  localparam logic [1:0] PH_HEADER  = 2'd1;
  localparam logic [1:0] PH_PIXEL   = 2'd2;
  localparam logic [1:0] PH_DONE    = 2'd3;

  localparam logic [8:0]  DEPTH9 = 9'(PALETTE_DEPTH);
  localparam logic [28:0] CAP    = 29'(MAX_SIDE * MAX_SIDE);

  // Configuration registers.
  logic [2:0]  pixel_bytes;
  logic        rle_mode;
  logic        swap_red_blue;
  logic        map_mode;
  logic [2:0]  map_entry_bytes;
  logic [8:0]  map_entries;
  logic [7:0]  map_first_index;
  logic [28:0] image_pixels;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_bytes     <= 3'd4;
      rle_mode        <= 1'b0;
      swap_red_blue   <= 1'b1;
      map_mode        <= 1'b0;
      map_entry_bytes <= 3'd3;
      map_entries     <= 9'd0;
      map_first_index <= 8'd0;
      image_pixels    <= 29'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        trpd_pkg::CFG_PIXEL_BYTES:     pixel_bytes     <= cfg_data[2:0];
        trpd_pkg::CFG_RLE_MODE:        rle_mode        <= cfg_data[0];
        trpd_pkg::CFG_SWAP_RED_BLUE:   swap_red_blue   <= cfg_data[0];
        trpd_pkg::CFG_MAP_MODE:        map_mode        <= cfg_data[0];
        trpd_pkg::CFG_MAP_ENTRY_BYTES: map_entry_bytes <= cfg_data[2:0];
        trpd_pkg::CFG_MAP_ENTRIES:     map_entries     <= cfg_data[8:0];
        trpd_pkg::CFG_MAP_FIRST_INDEX: map_first_index <= cfg_data[7:0];
        default:                       image_pixels    <= cfg_data[28:0];
      endcase
    end
  end

  // Decoder state.
  logic [1:0]  phase, phase_next;
  logic [10:0] count, count_next;
  logic [7:0]  pkt_left, pkt_left_next;
  logic        pkt_rep, pkt_rep_next;
  logic [31:0] asm_word, asm_word_next;
  logic [1:0]  bip, bip_next;
  logic [28:0] done, done_next;
  logic [31:0] entry, entry_next;

  // Derived configuration values.
  logic [2:0]  eb, pb;
  logic [8:0]  entries_eff;
  logic [10:0] pal_total;
  logic [28:0] total;
  logic [1:0]  after_pal, start_phase;

  always_comb begin
    eb          = trpd_pkg::clamp_bytes(map_entry_bytes);
    pb          = trpd_pkg::clamp_bytes(pixel_bytes);
    entries_eff = (map_entries > DEPTH9) ? DEPTH9 : map_entries;
    pal_total   = 11'(entries_eff) * 11'(eb);
    if (image_pixels == 29'd0) begin
      total = 29'd1;
    end else if (image_pixels > CAP) begin
      total = CAP;
    end else begin
      total = image_pixels;
    end
    after_pal   = rle_mode ? PH_HEADER : PH_PIXEL;
    start_phase = (map_mode && entries_eff != 9'd0) ? PH_PALETTE : after_pal;
  end

  // State as seen by this byte, after an image start has cleared it.
  logic [1:0]  c_phase;
  logic [10:0] c_count;
  logic [7:0]  c_pl;
  logic        c_rep;
  logic [31:0] c_asm;
  logic [1:0]  c_bip;
  logic [28:0] c_done;

  always_comb begin
    c_phase = image_start ? start_phase : phase;
    c_count = image_start ? 11'd0 : count;
    c_pl    = image_start ? 8'd0 : pkt_left;
    c_rep   = image_start ? 1'b0 : pkt_rep;
    c_asm   = image_start ? 32'd0 : asm_word;
    c_bip   = image_start ? 2'd0 : bip;
    c_done  = image_start ? 29'd0 : done;
  end

  // Palette byte position and loaded entry count.
  logic        pal_active;
  logic [1:0]  ph1;
  logic [10:0] quot;
  logic [3:0]  qe_lo;
  logic [1:0]  pos;
  logic [31:0] entry_new, entry_word;
  logic        wr_fire;
  logic [10:0] count_inc;

  always_comb begin
    pal_active = (c_phase == PH_PALETTE) && map_mode && (c_count < pal_total);
    ph1        = (c_phase == PH_PALETTE && !pal_active) ? after_pal : c_phase;
    quot       = trpd_pkg::div_small(c_count, eb);
    qe_lo      = quot[1:0] * eb[1:0];
    pos        = c_count[1:0] - qe_lo[1:0];
    if (pos == 2'd0) begin
      entry_new = {24'd0, data_byte};
    end else begin
      entry_new = entry | (32'(data_byte) << {pos, 3'b000});
    end
    entry_word = (eb >= 3'd3 && swap_red_blue) ? trpd_pkg::swap02(entry_new) : entry_new;
    wr_fire    = (pos == 2'(eb - 3'd1));
    count_inc  = c_count + 11'd1;
  end

  // Pixel assembly and palette range check.
  logic [31:0] asm_new;
  logic [1:0]  bip_new;
  logic        complete;
  logic [8:0]  loaded;
  logic [9:0]  low10, diff10;
  logic        in_range;
  logic [31:0] value;

  always_comb begin
    asm_new  = c_asm | (32'(data_byte) << {c_bip, 3'b000});
    bip_new  = c_bip + 2'd1;
    complete = (bip_new == 2'd0) || ({1'b0, bip_new} >= pb);
    loaded   = (quot > 11'(DEPTH9)) ? DEPTH9 : quot[8:0];
    low10    = asm_new[9:0];
    diff10   = low10 - {2'b00, map_first_index};
    in_range = (asm_new[31:10] == 22'd0) && (low10 >= {2'b00, map_first_index})
               && (diff10 < {1'b0, loaded});
    if (pb >= 3'd3 && swap_red_blue) begin
      value = trpd_pkg::swap02(asm_new);
    end else begin
      value = asm_new;
    end
  end

  // Run length, clipping and image end.
  logic [7:0]  run, pl_after, span;
  logic [29:0] rem;
  logic        wrapped, rem_small, last_n, last, clipped;
  logic [7:0]  emit;
  logic [28:0] done_new;

  always_comb begin
    if (c_pl == 8'd0) begin
      run      = 8'd1;
      pl_after = 8'd0;
      span     = 8'd1;
    end else if (c_rep) begin
      run      = c_pl;
      pl_after = 8'd0;
      span     = c_pl;
    end else begin
      run      = 8'd1;
      pl_after = c_pl - 8'd1;
      span     = c_pl;
    end
    rem       = {1'b0, total} - {1'b0, c_done};
    wrapped   = rem[29];
    rem_small = (rem[28:8] == 21'd0);
    last_n    = !wrapped && rem_small && (run >= rem[7:0]);
    clipped   = !wrapped && rem_small && (span > rem[7:0]);
    last      = wrapped || last_n;
    emit      = last_n ? rem[7:0] : run;
    done_new  = last_n ? total : (c_done + 29'(run));
  end

  // Next state and queue entry.
  always_comb begin
    phase_next    = phase;
    count_next    = count;
    pkt_left_next = pkt_left;
    pkt_rep_next  = pkt_rep;
    asm_word_next = asm_word;
    bip_next      = bip;
    done_next     = done;
    entry_next    = entry;
    push          = 1'b0;
    item          = '0;
    if (accept && c_phase != PH_DONE) begin
      phase_next    = ph1;
      count_next    = c_count;
      pkt_left_next = c_pl;
      pkt_rep_next  = c_rep;
      asm_word_next = c_asm;
      bip_next      = c_bip;
      done_next     = c_done;
      if (pal_active) begin
        count_next = count_inc;
        entry_next = entry_new;
        phase_next = (count_inc >= pal_total) ? after_pal : PH_PALETTE;
        if (wr_fire) begin
          push          = 1'b1;
          item.is_write = 1'b1;
          item.word     = entry_word;
          item.addr     = quot[trpd_pkg::IDX_W-1:0];
        end
      end else if (ph1 == PH_HEADER) begin
        pkt_rep_next  = data_byte[7];
        pkt_left_next = {1'b0, data_byte[6:0]} + 8'd1;
        bip_next      = 2'd0;
        asm_word_next = 32'd0;
        phase_next    = PH_PIXEL;
      end else if (!complete) begin
        asm_word_next = asm_new;
        bip_next      = bip_new;
      end else begin
        asm_word_next = 32'd0;
        bip_next      = 2'd0;
        pkt_left_next = pl_after;
        done_next     = done_new;
        if (last) begin
          phase_next = PH_DONE;
        end else if (pl_after == 8'd0 && rle_mode) begin
          phase_next = PH_HEADER;
        end else begin
          phase_next = PH_PIXEL;
        end
        push          = 1'b1;
        item.count    = emit;
        item.last     = last;
        item.clipped  = clipped;
        if (map_mode) begin
          item.lookup = in_range;
          item.bad    = !in_range;
          item.addr   = diff10[trpd_pkg::IDX_W-1:0];
        end else begin
          item.word   = value;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= (map_mode && entries_eff != 9'd0) ? PH_PALETTE : PH_PIXEL;
      count    <= 11'd0;
      pkt_left <= 8'd0;
      pkt_rep  <= 1'b0;
      asm_word <= 32'd0;
      bip      <= 2'd0;
      done     <= 29'd0;
    end else begin
      phase    <= phase_next;
      count    <= count_next;
      pkt_left <= pkt_left_next;
      pkt_rep  <= pkt_rep_next;
      asm_word <= asm_word_next;
      bip      <= bip_next;
      done     <= done_next;
    end
  end

  // Partial palette entry needs no reset.
  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule
`default_nettype wire

### rtl/trpd_queue.sv
// Short queue of palette writes and pixel results between the front and the back.
`default_nettype none
module trpd_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  trpd_pkg::qent_t      push_item,
  output logic                 full,
  input  wire logic            pop,
  output trpd_pkg::qent_t      head,
  output logic                 empty
);

  trpd_pkg::qent_t slots [trpd_pkg::QDEPTH];

  logic [trpd_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [trpd_pkg::QPTR_W:0]   fill;

  assign full  = (fill == (trpd_pkg::QPTR_W+1)'(trpd_pkg::QDEPTH));
  assign empty = (fill == '0);
  assign head  = slots[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/trpd_back.sv
// Back part: palette memory, lookup stage and output register.
`default_nettype none
module trpd_back #(
  parameter int PALETTE_DEPTH = trpd_pkg::DEF_PALETTE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  trpd_pkg::qent_t  head,
  input  wire logic        empty,
  output logic             pop,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,
  output logic             m_tlast,
  output logic [1:0]       m_tuser
);

  localparam int AW = $clog2(PALETTE_DEPTH);

  logic [31:0] palette [PALETTE_DEPTH];
  logic [31:0] rd_data;

  trpd_pkg::qent_t s1;
  logic            s1_valid;
  logic            s1_move, s1_free;

  logic [31:0] o_value;
  logic [7:0]  o_count;
  logic        o_last, o_clip, o_bad;
  logic        o_valid;

  assign s1_move = s1_valid && (!o_valid || m_tready);
  assign s1_free = !s1_valid || s1_move;
  assign pop     = !empty && (head.is_write || s1_free);

  // Palette writes and lookups leave the queue in order, so a lookup sees every earlier write.
  always_ff @(posedge clk) begin
    if (pop && head.is_write) begin
      palette[head.addr[AW-1:0]] <= head.word;
    end
    if (pop && !head.is_write) begin
      rd_data <= palette[head.addr[AW-1:0]];
    end
  end

  // Lookup stage holds the result fields while the read completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pop && !head.is_write) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && !head.is_write) begin
      s1 <= head;
    end
  end

  // Output register; it is refilled in the same cycle its beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (s1_move) begin
      o_valid <= 1'b1;
    end else if (m_tready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      o_value <= s1.lookup ? rd_data : s1.word;
      o_count <= s1.count;
      o_last  <= s1.last;
      o_clip  <= s1.clipped;
      o_bad   <= s1.bad;
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = {o_count, o_value};
  assign m_tlast  = o_last;
  assign m_tuser  = {o_bad, o_clip};

endmodule
`default_nettype wire

### rtl/tga_rle_pixel_decoder.sv
// Top level of the TGA run-length pixel decoder.
//
//  Channel   Direction  Beat contents
//  s_*       in         one stream byte; tuser marks the first byte of an image
//  m_*       out        one color with its repeat count; tlast marks the image end
//  cfg_*     in         register write, index and data, no read-back
//
// One byte is taken per clock while the queue between parser and lookup has room.
// From its last byte on, a result passes the queue, palette read and output register.
// Palette bytes and packet headers cause no result beat; the palette needs no clearing pass.
// Reset is synchronous; a stalled output fills the queue and then holds s_tready low.
`default_nettype none
module tga_rle_pixel_decoder #(
  parameter int PALETTE_DEPTH = trpd_pkg::DEF_PALETTE_DEPTH,
  parameter int MAX_SIDE      = trpd_pkg::DEF_MAX_SIDE
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [2:0]                 cfg_index,
  input  wire logic [trpd_pkg::CFG_W-1:0] cfg_data,
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  input  wire logic [7:0]                 s_tdata,   // [7:0] data_byte
  input  wire logic [0:0]                 s_tuser,   // [0] image_start
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  output logic [39:0]                     m_tdata,   // [31:0] pixel_value, [39:32] repeat_count
  output logic                            m_tlast,   // last_pixel
  output logic [1:0]                      m_tuser    // [0] clipped, [1] bad_index
);

  logic            accept;
  logic            push, full, pop, empty;
  trpd_pkg::qent_t push_item, head;

  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;

  trpd_front #(
    .PALETTE_DEPTH (PALETTE_DEPTH),
    .MAX_SIDE      (MAX_SIDE)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .data_byte   (s_tdata),
    .image_start (s_tuser[0]),
    .push        (push),
    .item        (push_item)
  );

  trpd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  trpd_back #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule
`default_nettype wire

### tb/tb_tga_rle_pixel_decoder.sv
// Self-checking testbench of the TGA run-length pixel decoder: directed and random byte streams.
module tb_tga_rle_pixel_decoder;
  import trpd_pkg::*;

  localparam int unsigned MAX_PIXELS    = 268435456;
  localparam int unsigned PALETTE_SLOTS = 256;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          LONG_HOLD     = 300;
  localparam int          STUCK_LIMIT   = 2000;
  localparam int          RANDOM_BYTES  = 400;

  // Register settings of one image.
  typedef struct packed {
    logic [2:0]  pixel_bytes;
    logic        rle_mode;
    logic        swap_red_blue;
    logic        map_mode;
    logic [2:0]  map_entry_bytes;
    logic [8:0]  map_entries;
    logic [7:0]  map_first_index;
    logic [28:0] image_pixels;
  } decode_setup_t;

  // One decoded pixel run as the output beat should carry it.
  typedef struct packed {
    logic [31:0] value;
    logic [7:0]  count;
    logic        last;
    logic        clipped;
    logic        bad;
  } pixel_result_t;

  typedef enum logic [1:0] {LOAD_PALETTE, READ_HEADER, READ_PIXELS, IMAGE_DONE} decode_phase_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [2:0]           cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata = '0;    // [7:0] data_byte
  logic [0:0]           s_tuser = '0;    // [0] image_start
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [39:0]          m_tdata;         // [31:0] pixel_value, [39:32] repeat_count
  logic                 m_tlast;
  logic [1:0]           m_tuser;         // [0] clipped, [1] bad_index

  // Decoder state as the testbench tracks it.
  decode_setup_t        setup;
  decode_phase_t        phase;
  logic [10:0]          pal_bytes;
  logic [31:0]          palette_colors [PALETTE_SLOTS];
  logic [7:0]           run_left;
  logic                 run_repeats;
  logic [31:0]          assembly;
  logic [1:0]           asm_bytes;
  int unsigned          pixels_out;

  pixel_result_t        pixels_due [$];
  logic [7:0]           stream_bytes [$];
  int                   bytes_decoded = 0;
  int                   mismatches = 0;
  logic                 steady = 1'b0;
  int                   hold_requests = 0;
  int                   holds_served = 0;
  int                   stall_left = 0;

  tga_rle_pixel_decoder i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

  always #5 clk = ~clk;

  // Register values right after reset.
  function automatic decode_setup_t reset_setup();
    decode_setup_t c;
    c.pixel_bytes     = 3'd4;
    c.rle_mode        = 1'b0;
    c.swap_red_blue   = 1'b1;
    c.map_mode        = 1'b0;
    c.map_entry_bytes = 3'd3;
    c.map_entries     = 9'd0;
    c.map_first_index = 8'd0;
    c.image_pixels    = 29'd1;
    return c;
  endfunction

  // A byte count of zero counts as one, anything above four as four.
  function automatic int unsigned byte_count(input logic [2:0] v);
    if (v == 3'd0) return 1;
    if (v > 3'd4) return 4;
    return v;
  endfunction

  function automatic int unsigned entries_in_use();
    return (setup.map_entries > PALETTE_SLOTS) ? PALETTE_SLOTS : setup.map_entries;
  endfunction

  function automatic logic [31:0] exchange_red_blue(input logic [31:0] v);
    return {v[31:24], v[7:0], v[15:8], v[23:16]};
  endfunction

  function automatic decode_phase_t phase_after_palette();
    return setup.rle_mode ? READ_HEADER : READ_PIXELS;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [2:0] pick_bytes();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return 3'd1;
    if (r < 6) return 3'd3;
    if (r < 8) return 3'd4;
    return 3'($urandom_range(0, 7));
  endfunction

  // Start of an image: all counters cleared, phase chosen from the settings.
  task automatic clear_decoder();
    pal_bytes   = '0;
    run_left    = '0;
    run_repeats = 1'b0;
    assembly    = '0;
    asm_bytes   = '0;
    pixels_out  = 0;
    phase = (setup.map_mode && entries_in_use() > 0) ? LOAD_PALETTE : phase_after_palette();
  endtask

  // Track one accepted stream byte and queue the pixel run it completes, if any.
  task automatic decode_byte(input logic [7:0] b, input logic start, output logic used);
    int unsigned   eb, pb, total, pal_total, slot, pos, loaded, raw, run, remaining, emit;
    pixel_result_t r;
    eb = byte_count(setup.map_entry_bytes);
    pb = byte_count(setup.pixel_bytes);
    total = (setup.image_pixels == 0) ? 1 : setup.image_pixels;
    if (total > MAX_PIXELS) total = MAX_PIXELS;
    used = 1'b0;
    if (start) clear_decoder();
    if (phase == IMAGE_DONE) return;
    used = 1'b1;

    // Palette bytes fill entries little-endian; wide entries may get red and blue exchanged.
    if (phase == LOAD_PALETTE) begin
      pal_total = entries_in_use() * eb;
      if (setup.map_mode && pal_bytes < pal_total) begin
        slot = pal_bytes / eb;
        pos  = pal_bytes % eb;
        if (pos == 0) begin
          palette_colors[slot] = 32'(b);
        end else begin
          palette_colors[slot] = palette_colors[slot] | (32'(b) << (8 * pos));
        end
        if (pos == eb - 1 && eb >= 3 && setup.swap_red_blue) begin
          palette_colors[slot] = exchange_red_blue(palette_colors[slot]);
        end
        pal_bytes = pal_bytes + 11'd1;
        if (pal_bytes >= pal_total) phase = phase_after_palette();
        return;
      end
      phase = phase_after_palette();
    end

    // Packet header: bit 7 marks a repeat, the low bits plus one give the run.
    if (phase == READ_HEADER) begin
      run_repeats = b[7];
      run_left    = {1'b0, b[6:0]} + 8'd1;
      asm_bytes   = '0;
      assembly    = '0;
      phase       = READ_PIXELS;
      return;
    end

    // Pixel bytes are gathered until a whole pixel or index is there.
    assembly  = assembly | (32'(b) << (8 * asm_bytes));
    asm_bytes = asm_bytes + 2'd1;
    if (asm_bytes != 0 && asm_bytes < pb) return;
    raw       = assembly;
    assembly  = '0;
    asm_bytes = '0;

    r.bad = 1'b0;
    if (setup.map_mode) begin
      loaded = pal_bytes / eb;
      if (loaded > PALETTE_SLOTS) loaded = PALETTE_SLOTS;
      if (raw >= setup.map_first_index && raw - setup.map_first_index < loaded) begin
        r.value = palette_colors[raw - setup.map_first_index];
      end else begin
        r.value = '0;
        r.bad   = 1'b1;
      end
    end else begin
      r.value = raw;
      if (pb >= 3 && setup.swap_red_blue) r.value = exchange_red_blue(r.value);
    end

    // Run length of this beat and what is left of the packet.
    if (run_left == 0) begin
      run = 1;
    end else if (run_repeats) begin
      run      = run_left;
      run_left = '0;
    end else begin
      run      = 1;
      run_left = run_left - 8'd1;
    end
    if (run_left == 0 && setup.rle_mode) phase = READ_HEADER;

    // Clip at the image end.
    remaining  = total - pixels_out;
    emit       = (run < remaining) ? run : remaining;
    r.clipped  = (run + run_left > remaining);
    pixels_out = pixels_out + emit;
    r.last     = (pixels_out >= total);
    if (r.last) phase = IMAGE_DONE;
    r.count = 8'(emit);
    pixels_due.push_back(r);
  endtask

  // Offer one byte after an optional gap and hold it until the block takes it.
  task automatic send_byte(input logic [7:0] b, input logic start);
    int   gap;
    logic used;
    gap = steady ? 0 : idle_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= start;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    decode_byte(b, start, used);
    if (used) bytes_decoded++;
  endtask

  task automatic send_stream(input logic new_image);
    for (int k = 0; k < stream_bytes.size(); k++) begin
      send_byte(stream_bytes[k], new_image && k == 0);
    end
    stream_bytes.delete();
  endtask

  // Stop sending and wait until every pixel run is out and the pipeline has settled.
  task automatic wait_for_idle();
    s_tvalid <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all eight registers, one per clock.
  task automatic apply_config(input decode_setup_t c);
    for (int i = CFG_PIXEL_BYTES; i <= CFG_IMAGE_PIXELS; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= 3'(i);
      case (3'(i))
        CFG_PIXEL_BYTES:     cfg_data <= CFG_W'(c.pixel_bytes);
        CFG_RLE_MODE:        cfg_data <= CFG_W'(c.rle_mode);
        CFG_SWAP_RED_BLUE:   cfg_data <= CFG_W'(c.swap_red_blue);
        CFG_MAP_MODE:        cfg_data <= CFG_W'(c.map_mode);
        CFG_MAP_ENTRY_BYTES: cfg_data <= CFG_W'(c.map_entry_bytes);
        CFG_MAP_ENTRIES:     cfg_data <= CFG_W'(c.map_entries);
        CFG_MAP_FIRST_INDEX: cfg_data <= CFG_W'(c.map_first_index);
        default:             cfg_data <= CFG_W'(c.image_pixels);
      endcase
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    setup = c;
  endtask

  task automatic play_image(input decode_setup_t c);
    wait_for_idle();
    apply_config(c);
    send_stream(1'b1);
  endtask

  // Settings left by reset: 4-byte pixels with red/blue exchange, one-pixel image.
  task automatic test_reset_defaults();
    stream_bytes = '{8'h11, 8'h22, 8'h33, 8'h44, 8'h99};
    send_stream(1'b1);
  endtask

  // Raw true-color pixels of every byte count, odd counts included.
  task automatic test_truecolor_raw();
    decode_setup_t c;
    c = reset_setup();
    c.pixel_bytes  = 3'd3;
    c.image_pixels = 29'd2;
    stream_bytes = '{8'hFF, 8'h00, 8'h80, 8'h01, 8'hFF, 8'h7F};
    play_image(c);
    // Two-byte pixels are never exchanged.
    c.pixel_bytes  = 3'd2;
    c.image_pixels = 29'd1;
    stream_bytes = '{8'h12, 8'h34};
    play_image(c);
    c.pixel_bytes  = 3'd0;
    c.image_pixels = 29'd2;
    stream_bytes = '{8'h5A, 8'hA5};
    play_image(c);
    c.pixel_bytes   = 3'd7;
    c.swap_red_blue = 1'b0;
    c.image_pixels  = 29'd1;
    stream_bytes = '{8'h01, 8'h02, 8'h03, 8'h04};
    play_image(c);
  endtask

  // Longest repeat, a literal packet, and runs cut at the image end.
  task automatic test_rle_packets();
    decode_setup_t c;
    c = reset_setup();
    c.pixel_bytes   = 3'd3;
    c.swap_red_blue = 1'b0;
    c.rle_mode      = 1'b1;
    c.image_pixels  = 29'd130;
    stream_bytes = '{8'hFF, 8'h10, 8'h20, 8'h30, 8'h00, 8'h40, 8'h50, 8'h60,
                     8'h81, 8'h70, 8'h80, 8'h90, 8'h55};
    play_image(c);
    c.image_pixels = 29'd2;
    stream_bytes = '{8'h02, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09};
    play_image(c);
  endtask

  // Palette loads and lookups, indices below and past the loaded entries.
  task automatic test_palette_lookup();
    decode_setup_t c;
    c = reset_setup();
    c.map_mode        = 1'b1;
    c.map_entry_bytes = 3'd3;
    c.map_entries     = 9'd2;
    c.map_first_index = 8'd254;
    c.pixel_bytes     = 3'd1;
    c.image_pixels    = 29'd3;
    stream_bytes = '{8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'hFE, 8'hFF, 8'hFD};
    play_image(c);
    c.map_entry_bytes = 3'd0;
    c.map_entries     = 9'd1;
    c.map_first_index = 8'd0;
    c.pixel_bytes     = 3'd0;
    c.image_pixels    = 29'd2;
    stream_bytes = '{8'hC3, 8'h00, 8'h01};
    play_image(c);
    // Four-byte entries and four-byte indices inside a repeat packet.
    c.map_entry_bytes = 3'd4;
    c.pixel_bytes     = 3'd4;
    c.rle_mode        = 1'b1;
    c.image_pixels    = 29'd3;
    stream_bytes = '{8'h11, 8'h22, 8'h33, 8'h44, 8'h82, 8'h00, 8'h00, 8'h00, 8'h00};
    play_image(c);
  endtask

  // Image sizes of zero, of exactly the largest side squared and beyond it.
  task automatic test_image_size_limits();
    decode_setup_t c;
    c = reset_setup();
    c.pixel_bytes  = 3'd1;
    c.image_pixels = 29'd0;
    stream_bytes = '{8'hAA, 8'hBB};
    play_image(c);
    c.rle_mode     = 1'b1;
    c.image_pixels = 29'h1FFFFFFF;
    stream_bytes = '{8'hFF, 8'h3C};
    play_image(c);
    c.image_pixels = 29'd268435456;
    stream_bytes = '{8'hFF, 8'hC3, 8'h00, 8'h7E};
    play_image(c);
  endtask

  // Settings changed while an image is half done, and a restart in mid-pixel.
  task automatic test_config_mid_image();
    decode_setup_t c;
    c = reset_setup();
    c.pixel_bytes  = 3'd1;
    c.rle_mode     = 1'b1;
    c.image_pixels = 29'd10;
    stream_bytes = '{8'h03, 8'hA1, 8'hA2};
    play_image(c);
    // The open literal packet runs out, then the stream is raw.
    wait_for_idle();
    c.rle_mode = 1'b0;
    apply_config(c);
    stream_bytes = '{8'hA3, 8'hA4, 8'hA5, 8'hA6};
    send_stream(1'b0);

    c = reset_setup();
    c.map_mode        = 1'b1;
    c.map_entry_bytes = 3'd1;
    c.map_entries     = 9'd4;
    c.pixel_bytes     = 3'd1;
    c.image_pixels    = 29'd3;
    stream_bytes = '{8'h10, 8'h20};
    play_image(c);
    // The palette count is already past the new entry count: the next byte is an index.
    wait_for_idle();
    c.map_entries = 9'd1;
    apply_config(c);
    stream_bytes = '{8'h01, 8'h00, 8'h02};
    send_stream(1'b0);

    c = reset_setup();
    c.pixel_bytes  = 3'd3;
    c.image_pixels = 29'd4;
    stream_bytes = '{8'h01, 8'h02, 8'h03, 8'h04, 8'h05};
    play_image(c);
    stream_bytes = '{8'h06, 8'h07, 8'h08};
    play_image(c);
  endtask

  // All 256 palette entries loaded, the top one looked up.
  task automatic test_full_palette();
    decode_setup_t c;
    c = reset_setup();
    c.map_mode        = 1'b1;
    c.map_entry_bytes = 3'd1;
    c.map_entries     = 9'd256;
    c.pixel_bytes     = 3'd1;
    c.rle_mode        = 1'b1;
    c.image_pixels    = 29'd5;
    repeat (256) stream_bytes.push_back(8'($urandom));
    stream_bytes.push_back(8'h03);
    stream_bytes.push_back(8'h00);
    stream_bytes.push_back(8'hFF);
    stream_bytes.push_back(8'h80);
    stream_bytes.push_back(8'h07);
    stream_bytes.push_back(8'h80);
    stream_bytes.push_back(8'hFF);
    play_image(c);
  endtask

  // The output stalls for a long stretch while bytes keep coming.
  task automatic test_output_backpressure();
    decode_setup_t c;
    c = reset_setup();
    c.pixel_bytes  = 3'd1;
    c.image_pixels = 29'd60;
    repeat (60) stream_bytes.push_back(8'($urandom));
    steady = 1'b1;
    hold_requests++;
    play_image(c);
    steady = 1'b0;
  endtask

  // One pixel or index; index bytes mostly land near the loaded palette.
  task automatic push_pixel(input decode_setup_t c, input int unsigned pb,
                            input int unsigned n_entries);
    int unsigned idx;
    for (int k = 0; k < pb; k++) begin
      if (!c.map_mode) begin
        stream_bytes.push_back(8'($urandom));
      end else if (k == 0) begin
        idx = c.map_first_index + $urandom_range(0, n_entries + 3) - 2;
        stream_bytes.push_back(8'(idx));
      end else begin
        stream_bytes.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'h00);
      end
    end
  endtask

  // Random settings and a mostly well-formed image, sometimes cut short or trailed by noise.
  task automatic random_image();
    decode_setup_t c;
    int unsigned   eb, pb, n_entries, goal, made, run;
    logic          repeat_pkt;
    c.pixel_bytes     = pick_bytes();
    c.rle_mode        = 1'($urandom_range(0, 1));
    c.swap_red_blue   = 1'($urandom_range(0, 1));
    c.map_mode        = ($urandom_range(0, 2) == 0);
    c.map_entry_bytes = pick_bytes();
    c.map_entries     = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(0, 256))
                                                    : 9'($urandom_range(0, 6));
    c.map_first_index = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 19))
      0:       c.image_pixels = 29'd0;
      1:       c.image_pixels = 29'h1FFFFFFF;
      2:       c.image_pixels = 29'd268435456;
      default: c.image_pixels = 29'($urandom_range(1, 40));
    endcase
    eb        = byte_count(c.map_entry_bytes);
    pb        = byte_count(c.pixel_bytes);
    n_entries = (c.map_entries > PALETTE_SLOTS) ? PALETTE_SLOTS : c.map_entries;
    if (c.image_pixels == 0) begin
      goal = 1;
    end else if (c.image_pixels > 40) begin
      goal = $urandom_range(5, 30);
    end else begin
      goal = c.image_pixels;
    end

    if (c.map_mode) repeat (n_entries * eb) stream_bytes.push_back(8'($urandom));
    made = 0;
    while (made < goal) begin
      if (c.rle_mode) begin
        run = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 6);
        repeat_pkt = 1'($urandom_range(0, 1));
        stream_bytes.push_back({repeat_pkt, 7'(run - 1)});
        repeat (repeat_pkt ? 1 : run) push_pixel(c, pb, n_entries);
      end else begin
        run = 1;
        push_pixel(c, pb, n_entries);
      end
      made += run;
    end
    // A broken stream is cut anywhere; the next image start recovers.
    if ($urandom_range(0, 9) == 0) begin
      run = $urandom_range(1, stream_bytes.size());
      while (stream_bytes.size() > run) void'(stream_bytes.pop_back());
    end
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) stream_bytes.push_back(8'($urandom));
    end
    steady = ($urandom_range(0, 4) == 0);
    play_image(c);
  endtask

  task automatic test_random_images();
    int target;
    target = bytes_decoded + RANDOM_BYTES;
    while (bytes_decoded < target) random_image();
    steady = 1'b0;
  endtask

  // Output side: check each beat against the oldest queued run, then pick the next stall.
  always @(posedge clk) begin : result_side
    pixel_result_t due;
    int            n;
    if (!rst && m_tvalid && m_tready) begin
      if (pixels_due.size() == 0) begin
        $error("result beat with nothing expected: pixel_value %h", m_tdata[31:0]);
        mismatches++;
      end else begin
        due = pixels_due.pop_front();
        if (m_tdata[31:0] !== due.value) begin
          $error("pixel_value expected %h actual %h", due.value, m_tdata[31:0]);
          mismatches++;
        end
        if (m_tdata[39:32] !== due.count) begin
          $error("repeat_count expected %0d actual %0d", due.count, m_tdata[39:32]);
          mismatches++;
        end
        if (m_tlast !== due.last) begin
          $error("last_pixel expected %b actual %b", due.last, m_tlast);
          mismatches++;
        end
        if (m_tuser[0] !== due.clipped) begin
          $error("clipped expected %b actual %b", due.clipped, m_tuser[0]);
          mismatches++;
        end
        if (m_tuser[1] !== due.bad) begin
          $error("bad_index expected %b actual %b", due.bad, m_tuser[1]);
          mismatches++;
        end
      end
    end

    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (holds_served < hold_requests) begin
      holds_served++;
      stall_left = LONG_HOLD - 1;
      m_tready <= 1'b0;
    end else begin
      n = steady ? 0 : idle_len();
      if (n > 0) begin
        stall_left = n - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog: too many cycles without any beat or register write ends the run.
  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if (rst || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        stuck = 0;
      end else begin
        stuck++;
      end
    end
    $display("tb_tga_rle_pixel_decoder NOT OK");
    $finish;
  end

  // Test sequence.
  initial begin
    setup = reset_setup();
    clear_decoder();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_truecolor_raw();
    test_rle_packets();
    test_palette_lookup();
    test_image_size_limits();
    test_config_mid_image();
    test_full_palette();
    test_output_backpressure();
    test_random_images();
    wait_for_idle();
    if (mismatches == 0) begin
      $display("tb_tga_rle_pixel_decoder OK");
    end else begin
      $display("tb_tga_rle_pixel_decoder NOT OK");
    end
    $finish;
  end

endmodule
